FILE: src/xor_distance_bucket_table_defines.svh
// Assertion macros shared by the bucket table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef XOR_DISTANCE_BUCKET_TABLE_DEFINES_SVH
`define XOR_DISTANCE_BUCKET_TABLE_DEFINES_SVH

// Condition must hold at every edge outside reset
`define XDBT_ASSERT_ALW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define XDBT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define XDBT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/xdbt_pkg.sv
// Types, codes and default sizes for the XOR-distance bucket table.
// No dependencies; imported by every module of the block but xdbt_ram.
`default_nettype none
package xdbt_pkg;

   // Default sizes, handed down to the top level parameters
   localparam int DEF_ID_BITS      = 64;
   localparam int DEF_BUCKETS      = 64;
   localparam int DEF_BUCKET_DEPTH = 8;
   localparam int DEF_MAX_FIND     = 16;

   // Fixed field widths
   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 16;
   localparam int LIMIT_W  = 5;
   localparam int BKT_W    = 6;
   localparam int FILL_W   = 4;
   localparam int TOTAL_W  = 10;
   localparam int OUT_CAP  = 16;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_FIND = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_ADDED = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_FOUND = 2'd2,
      STATUS_NONE  = 2'd3
   } status_type;

   // Classified request as queued for the back end
   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [HANDLE_W-1:0]  handle;
      logic [BKT_W-1:0]     bucket;
      logic [LIMIT_W-1:0]   limit;
   } cmd_type;

   // One result as driven onto the response ports
   typedef struct packed {
      logic                 strobe;
      status_type           status;
      logic [KEY_W-1:0]     key;
      logic [HANDLE_W-1:0]  handle;
      logic [BKT_W-1:0]     bucket;
      logic                 last;
   } rsp_type;

endpackage
`default_nettype wire

FILE: src/xdbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module xdbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: src/xdbt_cmd_queue.sv
// Short queue of classified requests between front and back end.
// Depends on xdbt_pkg and the assertion macro header.
`default_nettype none
`include "xor_distance_bucket_table_defines.svh"
module xdbt_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xdbt_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output xdbt_pkg::cmd_type      pop_data
);
   import xdbt_pkg::*;

   localparam int AW = (QUEUE_AW > 0) ? QUEUE_AW : 1;

   cmd_type               mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `XDBT_ASSERT_ALW(a_queue_bound, clock, reset, count_ff <= QUEUE_CW'(QUEUE_DEPTH), "queue overfilled")

endmodule
`default_nettype wire

FILE: src/xdbt_front.sv
// Front end: accepts requests, computes XOR distance and bucket, clamps the count.
// Depends on xdbt_pkg; feeds xdbt_cmd_queue.
`default_nettype none
module xdbt_front #(
   parameter int ID_BITS  = xdbt_pkg::DEF_ID_BITS,
   parameter int BUCKETS  = xdbt_pkg::DEF_BUCKETS,
   parameter int MAX_FIND = xdbt_pkg::DEF_MAX_FIND
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_operation,
   input  wire logic [xdbt_pkg::KEY_W-1:0]    req_node_key,
   input  wire logic [xdbt_pkg::HANDLE_W-1:0] req_peer_handle,
   input  wire logic [xdbt_pkg::LIMIT_W-1:0]  req_max_results,
   input  wire logic [xdbt_pkg::KEY_W-1:0]    local_node_id,
   output logic                               push,
   output xdbt_pkg::cmd_type                  push_data,
   input  wire logic                          queue_full
);
   import xdbt_pkg::*;

   localparam int NGRP = (ID_BITS + 7) / 8;
   localparam int PADW = NGRP * 8;
   localparam int PAD  = PADW - ID_BITS;
   localparam logic [KEY_W-1:0] ID_MASK =
      (ID_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << ID_BITS) - KEY_W'(1));

   logic                 s1_vld_ff, s1_vld_in;
   cmd_type              s1_cmd_ff, s1_cmd_in;
   logic [NGRP-1:0]      s1_nz_ff, s1_nz_in;
   logic [2:0]           s1_glz_ff [NGRP];
   logic [2:0]           s1_glz_in [NGRP];

   logic                 accept;
   logic [KEY_W-1:0]     key_cut;
   logic [KEY_W-1:0]     xor_dist;
   logic [PADW-1:0]      dist_pad;
   logic [LIMIT_W-1:0]   limit;
   logic [6:0]           lz;
   logic [BKT_W-1:0]     bucket;

   assign busy    = s1_vld_ff || queue_full;
   assign accept  = start && !busy;
   assign key_cut = req_node_key & ID_MASK;
   assign xor_dist = key_cut ^ (local_node_id & ID_MASK);
   assign dist_pad = PADW'(xor_dist) << PAD;

   // Clamp the requested count to the find limit and output capacity
   always_comb begin
      limit = req_max_results;
      if (int'(limit) > MAX_FIND) begin
         limit = LIMIT_W'(MAX_FIND);
      end
      if (int'(limit) > OUT_CAP) begin
         limit = LIMIT_W'(OUT_CAP);
      end
   end

   // Leading zeros within each byte group, most significant group first
   always_comb begin
      logic [7:0] grp;
      for (int g = 0; g < NGRP; g++) begin
         grp          = dist_pad[PADW-1-8*g -: 8];
         s1_nz_in[g]  = (grp != 8'd0);
         s1_glz_in[g] = 3'd0;
         for (int i = 0; i < 8; i++) begin
            if (grp[i]) begin
               s1_glz_in[g] = 3'(7 - i);
            end
         end
      end
   end

   // Combine groups into the bucket index, clamped to the last bucket
   always_comb begin
      lz = 7'd0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (s1_nz_ff[g]) begin
            lz = 7'(g * 8) + 7'(s1_glz_ff[g]);
         end
      end
      if (lz > 7'(BUCKETS - 1)) begin
         lz = 7'(BUCKETS - 1);
      end
      bucket = lz[BKT_W-1:0];
   end

   assign push = s1_vld_ff;
   always_comb begin
      push_data        = s1_cmd_ff;
      push_data.bucket = bucket;
   end

   // Capture the request; hold it while the queue is full
   always_comb begin
      s1_cmd_in.op     = op_type'(req_operation);
      s1_cmd_in.key    = key_cut;
      s1_cmd_in.handle = req_peer_handle;
      s1_cmd_in.bucket = '0;
      s1_cmd_in.limit  = limit;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else begin
         s1_vld_in = s1_vld_ff && queue_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      if (accept) begin
         s1_cmd_ff <= s1_cmd_in;
         s1_nz_ff  <= s1_nz_in;
         s1_glz_ff <= s1_glz_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/xdbt_back.sv
// Back end: bucket fill counts and entry store, carries out adds and finds.
// Depends on xdbt_pkg, xdbt_ram and the assertion macro header.
`default_nettype none
`include "xor_distance_bucket_table_defines.svh"
module xdbt_back #(
   parameter int ID_BITS      = xdbt_pkg::DEF_ID_BITS,
   parameter int BUCKETS      = xdbt_pkg::DEF_BUCKETS,
   parameter int BUCKET_DEPTH = xdbt_pkg::DEF_BUCKET_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire xdbt_pkg::cmd_type q_data,
   output xdbt_pkg::rsp_type      rsp
);
   import xdbt_pkg::*;

   localparam int BKT_AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOTS   = BUCKETS * BUCKET_DEPTH;
   localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENT_W   = ID_BITS + HANDLE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_FILLW,
      ST_ENT,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [BKT_W-1:0]      cur_ff, cur_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     j_ff, j_in;
   logic [LIMIT_W-1:0]    n_ff, n_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [ID_BITS-1:0]    pend_key_ff, pend_key_in;
   logic [HANDLE_W-1:0]   pend_handle_ff, pend_handle_in;
   logic [BKT_W-1:0]      pend_bkt_ff, pend_bkt_in;
   logic [BUCKETS-1:0]    valid_ff, valid_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   rsp_type               rsp_ff, rsp_in;

   logic [BKT_AW-1:0]     cur_idx;
   logic [FILL_W-1:0]     fill_rdata, fill_now;
   logic                  fill_we;
   logic [ENT_W-1:0]      ent_rdata;
   logic                  ent_we;
   logic [SLOT_AW-1:0]    ent_rd_addr, ent_wr_addr;

   assign cur_idx     = cur_ff[BKT_AW-1:0];
   assign fill_now    = valid_ff[cur_idx] ? fill_rdata : '0;
   assign ent_rd_addr = SLOT_AW'(int'(cur_ff) * BUCKET_DEPTH + int'(j_ff));
   assign ent_wr_addr = SLOT_AW'(int'(cur_ff) * BUCKET_DEPTH + int'(fill_now));
   assign rsp         = rsp_ff;

   // Per-bucket fill counts; a bucket not yet valid reads as empty
   xdbt_ram #(
      .WIDTH (FILL_W),
      .DEPTH (BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (cur_idx),
      .wr_data (fill_now + 1'b1),
      .rd_addr (cur_idx),
      .rd_data (fill_rdata)
   );

   // Stored keys and handles, one row per bucket slot
   xdbt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wr_addr),
      .wr_data ({cmd_ff.key[ID_BITS-1:0], cmd_ff.handle}),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rdata)
   );

   // Sequence one request at a time
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      cur_in         = cur_ff;
      fill_in        = fill_ff;
      j_in           = j_ff;
      n_in           = n_ff;
      pend_vld_in    = pend_vld_ff;
      pend_key_in    = pend_key_ff;
      pend_handle_in = pend_handle_ff;
      pend_bkt_in    = pend_bkt_ff;
      valid_in       = valid_ff;
      total_in       = total_ff;
      rsp_in         = rsp_ff;
      rsp_in.strobe  = 1'b0;
      q_pop          = 1'b0;
      fill_we        = 1'b0;
      ent_we         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               cmd_in      = q_data;
               cur_in      = q_data.bucket;
               n_in        = '0;
               pend_vld_in = 1'b0;
               state_in    = ST_FILL;
            end
         end

         // Fill count read in flight
         ST_FILL: begin
            state_in = ST_FILLW;
         end

         ST_FILLW: begin
            if (cmd_ff.op == OP_ADD) begin
               rsp_in.strobe = 1'b1;
               rsp_in.key    = '0;
               rsp_in.handle = '0;
               rsp_in.bucket = cur_ff;
               rsp_in.last   = 1'b1;
               if (fill_now < FILL_W'(BUCKET_DEPTH)) begin
                  ent_we            = 1'b1;
                  fill_we           = 1'b1;
                  valid_in[cur_idx] = 1'b1;
                  total_in          = total_ff + 1'b1;
                  rsp_in.status     = STATUS_ADDED;
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
               state_in = ST_IDLE;
            end else begin
               fill_in  = (fill_now > FILL_W'(BUCKET_DEPTH)) ? FILL_W'(BUCKET_DEPTH)
                                                            : fill_now;
               j_in     = '0;
               state_in = ST_ENT;
            end
         end

         // Next slot, next bucket down, or finish
         ST_ENT: begin
            if ((j_ff < fill_ff) && (n_ff < cmd_ff.limit)) begin
               j_in     = j_ff + 1'b1;
               n_in     = n_ff + 1'b1;
               state_in = ST_EMIT;
            end else if ((n_ff >= cmd_ff.limit) || (cur_ff == '0)) begin
               rsp_in.strobe = 1'b1;
               rsp_in.last   = 1'b1;
               if (pend_vld_ff) begin
                  rsp_in.status = STATUS_FOUND;
                  rsp_in.key    = KEY_W'(pend_key_ff);
                  rsp_in.handle = pend_handle_ff;
                  rsp_in.bucket = pend_bkt_ff;
               end else begin
                  rsp_in.status = STATUS_NONE;
                  rsp_in.key    = '0;
                  rsp_in.handle = '0;
                  rsp_in.bucket = cmd_ff.bucket;
               end
               state_in = ST_IDLE;
            end else begin
               cur_in   = cur_ff - 1'b1;
               state_in = ST_FILL;
            end
         end

         // Release the held entry and hold the new one, so the final one is marked
         ST_EMIT: begin
            if (pend_vld_ff) begin
               rsp_in.strobe = 1'b1;
               rsp_in.status = STATUS_FOUND;
               rsp_in.key    = KEY_W'(pend_key_ff);
               rsp_in.handle = pend_handle_ff;
               rsp_in.bucket = pend_bkt_ff;
               rsp_in.last   = 1'b0;
            end
            pend_vld_in    = 1'b1;
            pend_key_in    = ent_rdata[ENT_W-1:HANDLE_W];
            pend_handle_in = ent_rdata[HANDLE_W-1:0];
            pend_bkt_in    = cur_ff;
            state_in       = ST_ENT;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         n_ff          <= '0;
         pend_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         total_ff      <= '0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmd_ff         <= cmd_in;
         cur_ff         <= cur_in;
         fill_ff        <= fill_in;
         j_ff           <= j_in;
         n_ff           <= n_in;
         pend_vld_ff    <= pend_vld_in;
         pend_key_ff    <= pend_key_in;
         pend_handle_ff <= pend_handle_in;
         pend_bkt_ff    <= pend_bkt_in;
         valid_ff       <= valid_in;
         total_ff       <= total_in;
         rsp_ff         <= rsp_in;
      end
   end

   `XDBT_ASSERT_ALW(a_total_bound, clock, reset, total_ff <= TOTAL_W'(SLOTS), "entry count beyond table size")
   `XDBT_ASSERT_IMP(a_count_bound, clock, reset, state_ff != ST_IDLE, n_ff <= cmd_ff.limit, "find count beyond limit")
   `XDBT_ASSERT_IMP(a_slot_bound, clock, reset, state_ff == ST_ENT, j_ff <= fill_ff, "slot index beyond bucket fill")
   `XDBT_ASSERT_IMP(a_last_done, clock, reset, rsp_ff.strobe && rsp_ff.last, state_ff == ST_IDLE || state_ff == ST_FILL, "last result before request finished")
   `XDBT_ASSERT_NXT(a_pend_hold, clock, reset, state_ff == ST_EMIT, pend_vld_ff && state_ff == ST_ENT, "found entry not held")

endmodule
`default_nettype wire

FILE: src/xor_distance_bucket_table.sv
// Top level of the XOR-distance bucket table: local id register, front, queue, back.
// Depends on xdbt_pkg, xdbt_front, xdbt_cmd_queue, xdbt_back.
//
//   channel   ports                        handshake
//   request   req_*                        start high while busy low
//   result    rsp_*                        rsp_strobe, one cycle per result
//   config    csr_wr_en, csr_wr_data       write on csr_wr_en, no wait
//
// A request is registered in the front end, held while the queue is full, then waits in
// a two-entry queue. With the back end free, an add passes ST_FILL and ST_FILLW before
// its result is registered. A find walks each bucket via ST_FILL, ST_FILLW and ST_ENT,
// and returns up to 16 entries via ST_ENT and ST_EMIT (registered fill and entry reads).
// Reset is synchronous and clears all fill counts at once, no clearing pass.
// Results are never held off; busy is high the cycle after an accept and on a full queue.
`default_nettype none
module xor_distance_bucket_table #(
   parameter int ID_BITS      = xdbt_pkg::DEF_ID_BITS,
   parameter int BUCKETS      = xdbt_pkg::DEF_BUCKETS,
   parameter int BUCKET_DEPTH = xdbt_pkg::DEF_BUCKET_DEPTH,
   parameter int MAX_FIND     = xdbt_pkg::DEF_MAX_FIND
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_operation,
   input  wire logic [xdbt_pkg::KEY_W-1:0]    req_node_key,
   input  wire logic [xdbt_pkg::HANDLE_W-1:0] req_peer_handle,
   input  wire logic [xdbt_pkg::LIMIT_W-1:0]  req_max_results,
   input  wire logic                          csr_wr_en,
   input  wire logic [xdbt_pkg::KEY_W-1:0]    csr_wr_data,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [xdbt_pkg::KEY_W-1:0]         rsp_entry_key,
   output logic [xdbt_pkg::HANDLE_W-1:0]      rsp_entry_handle,
   output logic [xdbt_pkg::BKT_W-1:0]         rsp_bucket_number,
   output logic                               rsp_last
);
   import xdbt_pkg::*;

   logic [KEY_W-1:0] local_id_ff, local_id_in;
   logic             push, queue_full, q_valid, q_pop;
   cmd_type          push_data, q_data;
   rsp_type          rsp;

   // Local node id register
   assign local_id_in = csr_wr_en ? csr_wr_data : local_id_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         local_id_ff <= '0;
      end else begin
         local_id_ff <= local_id_in;
      end
   end

   xdbt_front #(
      .ID_BITS  (ID_BITS),
      .BUCKETS  (BUCKETS),
      .MAX_FIND (MAX_FIND)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_node_key    (req_node_key),
      .req_peer_handle (req_peer_handle),
      .req_max_results (req_max_results),
      .local_node_id   (local_id_ff),
      .push            (push),
      .push_data       (push_data),
      .queue_full      (queue_full)
   );

   xdbt_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

   xdbt_back #(
      .ID_BITS      (ID_BITS),
      .BUCKETS      (BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_data  (q_data),
      .rsp     (rsp)
   );

   // Drive the result ports
   assign rsp_strobe        = rsp.strobe;
   assign rsp_status        = rsp.status;
   assign rsp_entry_key     = rsp.key;
   assign rsp_entry_handle  = rsp.handle;
   assign rsp_bucket_number = rsp.bucket;
   assign rsp_last          = rsp.last;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for xor_distance_bucket_table: directed, then random add/find requests,
// each checked against an in-bench model of the bucket table. Depends on xdbt_pkg and the RTL.
module tb_top;
   import xdbt_pkg::*;

   localparam int NUM_BUCKETS     = DEF_BUCKETS;
   localparam int SLOTS_PER_BKT   = DEF_BUCKET_DEPTH;
   localparam int FIND_CAP        = (DEF_MAX_FIND < OUT_CAP) ? DEF_MAX_FIND : OUT_CAP;
   localparam int STALL_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 3 * NUM_BUCKETS + 2 * OUT_CAP + 20;
   localparam int ITEMS_PER_PHASE = 83;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      op_type                op;
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
      logic [LIMIT_W-1:0]    find_count;
   } request_t;

   typedef struct packed {
      status_type            status;
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
      logic [BKT_W-1:0]      bucket;
      logic                  last;
   } result_t;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  start           = 1'b0;
   logic                  busy;
   logic                  req_operation   = 1'b0;
   logic [KEY_W-1:0]      req_node_key    = '0;
   logic [HANDLE_W-1:0]   req_peer_handle = '0;
   logic [LIMIT_W-1:0]    req_max_results = '0;
   logic                  csr_wr_en       = 1'b0;
   logic [KEY_W-1:0]      csr_wr_data     = '0;
   logic                  rsp_strobe;
   logic [1:0]            rsp_status;
   logic [KEY_W-1:0]      rsp_entry_key;
   logic [HANDLE_W-1:0]   rsp_entry_handle;
   logic [BKT_W-1:0]      rsp_bucket_number;
   logic                  rsp_last;

   // Table model: local id, per-bucket fill and stored entries
   logic [KEY_W-1:0]      model_local_id = '0;
   logic [FILL_W-1:0]     model_fill [NUM_BUCKETS];
   logic [KEY_W-1:0]      model_keys [NUM_BUCKETS*SLOTS_PER_BKT];
   logic [HANDLE_W-1:0]   model_handles [NUM_BUCKETS*SLOTS_PER_BKT];

   request_t              pending_requests [$];
   result_t               awaited_results [$];
   request_t              in_flight;
   int                    sender_idle_pct = 21;
   int                    error_count = 0;
   int                    stall_cycles = 0;

   xor_distance_bucket_table u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_node_key      (req_node_key),
      .req_peer_handle   (req_peer_handle),
      .req_max_results   (req_max_results),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_handle  (rsp_entry_handle),
      .rsp_bucket_number (rsp_bucket_number),
      .rsp_last          (rsp_last)
   );

   always #6 clock = ~clock;

   // Bucket = leading zeros of the XOR distance, zero distance maps to bucket 0
   function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] distance;
      int idx;
      distance = key ^ model_local_id;
      idx = 0;
      for (int b = 0; b < KEY_W; b++)
         if (distance[b]) idx = KEY_W - 1 - b;
      if (idx > NUM_BUCKETS - 1) idx = NUM_BUCKETS - 1;
      return BKT_W'(idx);
   endfunction

   // Update the table model with one accepted request and queue its results
   function automatic void table_outcome(input request_t rq);
      logic [BKT_W-1:0] bkt;
      result_t res;
      int slot, limit, found;
      bkt = bucket_of(rq.key);
      res = '0;
      res.bucket = bkt;
      res.last = 1'b1;
      if (rq.op == OP_ADD) begin
         if (int'(model_fill[bkt]) < SLOTS_PER_BKT) begin
            slot = int'(bkt) * SLOTS_PER_BKT + int'(model_fill[bkt]);
            model_keys[slot] = rq.key;
            model_handles[slot] = rq.handle;
            model_fill[bkt] = model_fill[bkt] + 1'b1;
            res.status = STATUS_ADDED;
         end else begin
            res.status = STATUS_FULL;
         end
         awaited_results.push_back(res);
      end else begin
         limit = (int'(rq.find_count) > FIND_CAP) ? FIND_CAP : int'(rq.find_count);
         found = 0;
         // walk from the target bucket down to bucket 0, insertion order within each
         for (int b = int'(bkt); b >= 0; b--) begin
            for (int j = 0; j < int'(model_fill[b]); j++) begin
               if (found < limit) begin
                  slot = b * SLOTS_PER_BKT + j;
                  res.status = STATUS_FOUND;
                  res.key = model_keys[slot];
                  res.handle = model_handles[slot];
                  res.bucket = BKT_W'(b);
                  res.last = 1'b0;
                  awaited_results.push_back(res);
                  found++;
               end
            end
         end
         if (found == 0) begin
            res.status = STATUS_NONE;
            awaited_results.push_back(res);
         end else begin
            res = awaited_results.pop_back();
            res.last = 1'b1;
            awaited_results.push_back(res);
         end
      end
   endfunction

   task automatic queue_request(input op_type op, input logic [KEY_W-1:0] key,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [LIMIT_W-1:0] find_count);
      request_t rq;
      rq.op = op;
      rq.key = key;
      rq.handle = handle;
      rq.find_count = find_count;
      pending_requests.push_back(rq);
   endtask

   // Mostly keys at a chosen distance from the local id, biased to the low buckets
   function automatic logic [KEY_W-1:0] key_near(input logic [KEY_W-1:0] lid);
      logic [KEY_W-1:0] distance;
      int lz;
      distance = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 7) begin
         lz = ($urandom_range(0, 1) == 0) ? $urandom_range(0, KEY_W) : $urandom_range(0, 7);
         if (lz == KEY_W) begin
            distance = '0;
         end else begin
            distance = distance >> lz;
            distance[KEY_W-1-lz] = 1'b1;
         end
      end
      return lid ^ distance;
   endfunction

   // Mostly legal counts, now and then any 5-bit value including zero
   function automatic logic [LIMIT_W-1:0] random_limit();
      if ($urandom_range(0, 9) == 0) return LIMIT_W'($urandom_range(0, 31));
      return LIMIT_W'($urandom_range(1, 16));
   endfunction

   task automatic queue_random(input logic [KEY_W-1:0] lid, input int count);
      for (int i = 0; i < count; i++)
         queue_request(op_type'($urandom_range(0, 1)), key_near(lid),
                       HANDLE_W'($urandom), random_limit());
   endtask

   task automatic write_local_id(input logic [KEY_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_local_id = value;
   endtask

   // Hold until every request is sent and every result has come back
   task automatic wait_for_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || start || awaited_results.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: present the next pending request, idle at random
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) table_outcome(in_flight);
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               in_flight = pending_requests.pop_front();
               start           <= 1'b1;
               req_operation   <= in_flight.op;
               req_node_key    <= in_flight.key;
               req_peer_handle <= in_flight.handle;
               req_max_results <= in_flight.find_count;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each strobed result with the oldest awaited one
   always @(posedge clock) begin : result_monitor
      result_t seen, want;
      if (!reset && rsp_strobe) begin
         seen.status = status_type'(rsp_status);
         seen.key    = rsp_entry_key;
         seen.handle = rsp_entry_handle;
         seen.bucket = rsp_bucket_number;
         seen.last   = rsp_last;
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result status %0d key %h handle %h bucket %0d last %0d",
                        $realtime, seen.status, seen.key, seen.handle, seen.bucket, seen.last);
         end else begin
            want = awaited_results.pop_front();
            if (seen.status !== want.status || seen.key !== want.key ||
                seen.handle !== want.handle || seen.bucket !== want.bucket ||
                seen.last !== want.last) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: mismatch, expected status %0d key %h handle %h bucket %0d last %0d",
                           $realtime, want.status, want.key, want.handle, want.bucket, want.last);
                  $display("%0t:           got status %0d key %h handle %h bucket %0d last %0d",
                           $realtime, seen.status, seen.key, seen.handle, seen.bucket, seen.last);
               end
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no request or result accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
         $display("xor_distance_bucket_table regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : sequencer
      logic [KEY_W-1:0] lid;
      foreach (model_fill[i]) model_fill[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme keys, a bucket run to full, clamped counts
      write_local_id('0);
      sender_idle_pct = 21;
      queue_request(OP_FIND, 64'h0, 16'h0000, 5'd16);
      queue_request(OP_FIND, 64'h1, 16'hFFFF, 5'd0);
      queue_request(OP_ADD, 64'h0, 16'h0000, 5'd1);
      queue_request(OP_ADD, '1, 16'hFFFF, 5'd31);
      queue_request(OP_ADD, 64'h1, 16'h1234, 5'd1);
      queue_request(OP_ADD, 64'h2, 16'hEDCB, 5'd1);
      for (int i = 0; i < SLOTS_PER_BKT + 1; i++)
         queue_request(OP_ADD, 64'h0400_0000_0000_0000 | i, 16'hA55A ^ HANDLE_W'(i), 5'd1);
      queue_request(OP_FIND, 64'h1, 16'h0000, 5'd31);
      queue_request(OP_FIND, 64'h1, 16'h0000, 5'd1);
      queue_request(OP_FIND, 64'h0400_0000_0000_0000, 16'h0000, 5'd16);
      queue_request(OP_FIND, 64'h0000_0000_0001_0000, 16'h0000, 5'd3);
      queue_request(OP_FIND, 64'h0000_0001_0000_0000, 16'h0000, 5'd0);
      queue_request(OP_ADD, 64'h8000_0000_0000_0000, 16'h5AA5, 5'd1);
      queue_request(OP_FIND, 64'h0, 16'hFFFF, 5'd17);
      wait_for_idle();

      // Random phases, each under a fresh local id
      lid = '1;
      write_local_id(lid);
      queue_random(lid, ITEMS_PER_PHASE);
      wait_for_idle();

      sender_idle_pct = 88;
      lid = {$urandom, $urandom};
      write_local_id(lid);
      queue_random(lid, ITEMS_PER_PHASE);
      wait_for_idle();

      sender_idle_pct = 0;
      lid = {$urandom, $urandom};
      write_local_id(lid);
      queue_random(lid, ITEMS_PER_PHASE);
      wait_for_idle();

      // Let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("xor_distance_bucket_table regression: pass");
      else
         $display("xor_distance_bucket_table regression: fail");
      $finish;
   end

endmodule

FILE: xor_distance_bucket_table.f
+incdir+src
src/xdbt_pkg.sv
src/xdbt_ram.sv
src/xdbt_cmd_queue.sv
src/xdbt_front.sv
src/xdbt_back.sv
src/xor_distance_bucket_table.sv
tb/tb_top.sv
